>>> src/rtph264_pkg.sv
// Shared types and constants for the RTP H.264 depacketizer.
package rtph264_pkg;

    // NAL unit type that marks an FU-A fragmentation unit
    localparam logic [4:0] FU_A_TYPE = 5'd28;

    // Masks on the FU indicator and FU header
    localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;
    localparam logic [7:0] NRI_MASK      = 8'hE0;

    // Start code bytes
    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE  = 8'h01;

    // Saturation value of the statistic counters
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    // Kind of the packet in progress
    typedef enum logic [3:0] {
        KIND_NONE    = 4'b0001,
        KIND_SINGLE  = 4'b0010,
        KIND_FU_KEEP = 4'b0100,
        KIND_FU_DROP = 4'b1000
    } kind_t;

    // Emission command from the front end to the back end
    typedef struct packed {
        logic        start_code;
        logic        has_byte;
        logic [7:0]  data;
        logic        end_flag;
        logic        abort_flag;
        logic [31:0] ts;
        logic [31:0] lost;
        logic [31:0] reorder;
        logic [31:0] frames;
    } cmd_t;

endpackage

>>> src/rtph264_front.sv
// Front end: parses payload bytes, tracks packet and unit state, updates statistics.
module rtph264_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                packet_first,
    input  logic                packet_last,
    input  logic                packet_ok,
    input  logic [15:0]         seq_number,
    input  logic [31:0]         rtp_timestamp,
    output logic                push,
    output rtph264_pkg::cmd_t   cmd
);
    import rtph264_pkg::*;

    kind_t       kind_reg, kind_next;
    logic [1:0]  pos_reg, pos_next;
    logic [7:0]  ind_reg, ind_next;
    logic        open_reg, open_next;
    logic [31:0] ts_reg, ts_next;
    logic        skip_reg, skip_next;
    logic        feh_reg, feh_next;
    logic [15:0] exp_reg, exp_next;
    logic [31:0] lost_reg, lost_next;
    logic [31:0] reo_reg, reo_next;
    logic [31:0] frm_reg, frm_next;

    logic        sc, has_byte, end_flag, abort_flag, finish;
    logic [7:0]  out_data;
    logic [15:0] diff;
    logic [15:0] gap;
    logic [32:0] lost_sum;

    // Gap arithmetic for the loss counter
    assign diff     = seq_number - exp_reg;
    assign gap      = diff - 16'd1;
    assign lost_sum = {1'b0, lost_reg} + {17'd0, gap};

    // Classify the byte and compute the next state
    always_comb
    begin
        kind_next  = kind_reg;
        pos_next   = pos_reg;
        ind_next   = ind_reg;
        open_next  = open_reg;
        ts_next    = ts_reg;
        skip_next  = skip_reg;
        feh_next   = feh_reg;
        exp_next   = exp_reg;
        lost_next  = lost_reg;
        reo_next   = reo_reg;
        frm_next   = frm_reg;
        sc         = 1'b0;
        has_byte   = 1'b0;
        out_data   = data_byte;
        end_flag   = 1'b0;
        abort_flag = 1'b0;
        finish     = 1'b0;

        if (packet_first)
        begin
            // A new packet abandons a unit left open by a truncated one
            if (kind_reg != KIND_NONE && open_reg)
            begin
                abort_flag = 1'b1;
                open_next  = 1'b0;
            end
            kind_next = KIND_NONE;
            pos_next  = 2'd0;
            skip_next = 1'b0;
            feh_next  = 1'b0;
            if (!packet_ok)
            begin
                skip_next = 1'b1;
            end
            else
            begin
                if (seq_number != exp_reg)
                begin
                    reo_next = (reo_reg == CNT_MAX) ? CNT_MAX : reo_reg + 32'd1;
                    if (diff > 16'd1)
                    begin
                        lost_next = lost_sum[32] ? CNT_MAX : lost_sum[31:0];
                    end
                    if (open_next)
                    begin
                        abort_flag = 1'b1;
                        open_next  = 1'b0;
                    end
                end
                exp_next = seq_number + 16'd1;
                if (data_byte[4:0] == FU_A_TYPE)
                begin
                    kind_next = KIND_FU_KEEP;
                    ind_next  = data_byte;
                    pos_next  = 2'd1;
                end
                else
                begin
                    if (open_next)
                    begin
                        abort_flag = 1'b1;
                    end
                    kind_next = KIND_SINGLE;
                    open_next = 1'b1;
                    ts_next   = rtp_timestamp;
                    pos_next  = 2'd1;
                    sc        = 1'b1;
                    has_byte  = 1'b1;
                    finish    = packet_last;
                end
            end
        end
        else if (kind_reg == KIND_NONE || skip_reg)
        begin
            // drop orphan and skipped bytes
        end
        else if (kind_reg == KIND_SINGLE)
        begin
            has_byte = 1'b1;
            finish   = packet_last;
        end
        else if (pos_reg == 2'd1)
        begin
            // FU header
            pos_next = 2'd2;
            feh_next = data_byte[6];
            if (data_byte[7])
            begin
                if (open_reg)
                begin
                    abort_flag = 1'b1;
                end
                open_next = 1'b1;
                ts_next   = rtp_timestamp;
                kind_next = KIND_FU_KEEP;
                sc        = 1'b1;
                has_byte  = 1'b1;
                out_data  = (ind_reg & NRI_MASK) | (data_byte & NAL_TYPE_MASK);
                finish    = packet_last && data_byte[6];
            end
            else
            begin
                kind_next = open_reg ? KIND_FU_KEEP : KIND_FU_DROP;
                finish    = packet_last && open_reg && data_byte[6];
            end
        end
        else if (kind_reg == KIND_FU_KEEP)
        begin
            has_byte = 1'b1;
            finish   = packet_last && feh_reg;
        end

        // Close a completed unit
        if (finish)
        begin
            frm_next  = (frm_reg == CNT_MAX) ? CNT_MAX : frm_reg + 32'd1;
            open_next = 1'b0;
            end_flag  = 1'b1;
        end

        // Packet ends
        if (packet_last)
        begin
            kind_next = KIND_NONE;
            pos_next  = 2'd0;
            skip_next = 1'b0;
            feh_next  = 1'b0;
        end
    end

    // Hold state between transactions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_NONE;
            pos_reg  <= 2'd0;
            ind_reg  <= 8'd0;
            open_reg <= 1'b0;
            ts_reg   <= 32'd0;
            skip_reg <= 1'b0;
            feh_reg  <= 1'b0;
            exp_reg  <= 16'd0;
            lost_reg <= 32'd0;
            reo_reg  <= 32'd0;
            frm_reg  <= 32'd0;
        end
        else if (accept)
        begin
            kind_reg <= kind_next;
            pos_reg  <= pos_next;
            ind_reg  <= ind_next;
            open_reg <= open_next;
            ts_reg   <= ts_next;
            skip_reg <= skip_next;
            feh_reg  <= feh_next;
            exp_reg  <= exp_next;
            lost_reg <= lost_next;
            reo_reg  <= reo_next;
            frm_reg  <= frm_next;
        end
    end

    // Enqueue a command when the byte produces any result
    assign push = accept && (sc || has_byte || end_flag || abort_flag);

    always_comb
    begin
        cmd.start_code = sc;
        cmd.has_byte   = has_byte;
        cmd.data       = has_byte ? out_data : 8'd0;
        cmd.end_flag   = end_flag;
        cmd.abort_flag = abort_flag;
        cmd.ts         = ts_next;
        cmd.lost       = lost_next;
        cmd.reorder    = reo_next;
        cmd.frames     = frm_next;
    end

endmodule

>>> src/rtph264_queue.sv
// Command queue between the front end and the back end.
module rtph264_queue #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rtph264_pkg::cmd_t   push_cmd,
    input  logic                pop,
    output rtph264_pkg::cmd_t   head,
    output logic                not_empty,
    output logic                full
);
    import rtph264_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             store_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Write the entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wptr_reg] <= push_cmd;
        end
    end

    assign head      = store_reg[rptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));

endmodule

>>> src/rtph264_back.sv
// Back end: expands each command into start-code, data and marker results.
module rtph264_back (
    input  logic                clk,
    input  logic                rst_n,
    input  rtph264_pkg::cmd_t   head,
    input  logic                head_valid,
    output logic                pop,
    input  logic                result_stall,
    output logic                result_valid,
    output logic [7:0]          out_byte,
    output logic                byte_present,
    output logic                frame_end,
    output logic                frame_aborted,
    output logic [31:0]         frame_timestamp,
    output logic [31:0]         lost_total,
    output logic [31:0]         reorder_total,
    output logic [31:0]         frames_total,
    output logic                run_last
);
    import rtph264_pkg::*;

    logic [1:0]  sub_reg, sub_next;
    logic [1:0]  last_idx;
    logic        at_last;
    logic        load;
    logic [7:0]  res_byte;
    logic        res_present;

    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic        present_reg;
    logic        end_reg;
    logic        abort_reg;
    logic [31:0] ts_reg;
    logic [31:0] lost_reg;
    logic [31:0] reo_reg;
    logic [31:0] frm_reg;
    logic        last_reg;

    // Index of the final result of the head command
    assign last_idx = head.start_code ? (head.has_byte ? 2'd3 : 2'd2) : 2'd0;
    assign at_last  = (sub_reg == last_idx);

    // Select the result at the current position
    always_comb
    begin
        if (head.start_code && sub_reg != 2'd3)
        begin
            res_byte    = (sub_reg == 2'd2) ? SC_ONE : SC_ZERO;
            res_present = 1'b1;
        end
        else if (head.has_byte)
        begin
            res_byte    = head.data;
            res_present = 1'b1;
        end
        else
        begin
            res_byte    = 8'd0;
            res_present = 1'b0;
        end
    end

    assign load     = head_valid && (!valid_reg || !result_stall);
    assign pop      = load && at_last;
    assign sub_next = pop ? 2'd0 : sub_reg + 2'd1;

    // Advance through the results of the head command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                sub_reg <= sub_next;
            end
            if (!valid_reg || !result_stall)
            begin
                valid_reg <= head_valid;
            end
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg    <= res_byte;
            present_reg <= res_present;
            end_reg     <= head.end_flag && at_last;
            abort_reg   <= head.abort_flag && (sub_reg == 2'd0);
            ts_reg      <= head.ts;
            lost_reg    <= head.lost;
            reo_reg     <= head.reorder;
            frm_reg     <= head.frames;
            last_reg    <= at_last;
        end
    end

    assign result_valid    = valid_reg;
    assign out_byte        = byte_reg;
    assign byte_present    = present_reg;
    assign frame_end       = end_reg;
    assign frame_aborted   = abort_reg;
    assign frame_timestamp = ts_reg;
    assign lost_total      = lost_reg;
    assign reorder_total   = reo_reg;
    assign frames_total    = frm_reg;
    assign run_last        = last_reg;

endmodule

>>> src/rtp_h264_nal_depacketizer_top.sv
// Top level of the RTP H.264 depacketizer producing an Annex B byte stream.
// Takes one RTP payload byte per cycle while the command queue has room, and emits
// Annex B results, one per cycle while result_stall is low, through a registered
// output. A payload byte yields zero to four results: a byte that opens a NAL unit
// yields the 00 00 01 start code plus its own byte, four results in all. The input
// side keeps taking one byte per cycle as long as the FIFO_DEPTH-entry command queue
// between the parser and the result generator has room. An accepted byte passes
// through the command queue and the output register before its result appears.
// Marker-only results (byte_present 0) carry frame_end or frame_aborted alone.
// Statistic outputs show the counter values after the byte that caused the result.
module rtp_h264_nal_depacketizer_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [7:0]  data_byte,
    input  logic        packet_first,
    input  logic        packet_last,
    input  logic        packet_ok,
    input  logic [15:0] seq_number,
    input  logic [31:0] rtp_timestamp,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  out_byte,
    output logic        byte_present,
    output logic        frame_end,
    output logic        frame_aborted,
    output logic [31:0] frame_timestamp,
    output logic [31:0] lost_total,
    output logic [31:0] reorder_total,
    output logic [31:0] frames_total,
    output logic        run_last
);
    import rtph264_pkg::*;

    logic accept;
    logic q_push;
    logic q_pop;
    logic q_valid;
    logic q_full;
    cmd_t push_cmd;
    cmd_t head_cmd;

    assign item_stall = q_full;
    assign accept     = item_valid && !item_stall;

    // Parse bytes
    rtph264_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (data_byte),
        .packet_first  (packet_first),
        .packet_last   (packet_last),
        .packet_ok     (packet_ok),
        .seq_number    (seq_number),
        .rtp_timestamp (rtp_timestamp),
        .push          (q_push),
        .cmd           (push_cmd)
    );

    // Buffer commands
    rtph264_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .pop       (q_pop),
        .head      (head_cmd),
        .not_empty (q_valid),
        .full      (q_full)
    );

    // Generate results
    rtph264_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head_cmd),
        .head_valid      (q_valid),
        .pop             (q_pop),
        .result_stall    (result_stall),
        .result_valid    (result_valid),
        .out_byte        (out_byte),
        .byte_present    (byte_present),
        .frame_end       (frame_end),
        .frame_aborted   (frame_aborted),
        .frame_timestamp (frame_timestamp),
        .lost_total      (lost_total),
        .reorder_total   (reorder_total),
        .frames_total    (frames_total),
        .run_last        (run_last)
    );

    // The parser never writes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("command pushed into full queue");

    // A marker-only result carries exactly one of end and abort
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !byte_present |-> (frame_end ^ frame_aborted))
        else $error("marker result without a single marker flag");

    // A marker-only result is the only result of its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !byte_present |-> run_last)
        else $error("marker result not final");

    // The pop happens only when the queue has an entry
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

>>> tb/annexb_stream_checker.sv
// Checker that predicts and compares the Annex B results of the RTP H.264 depacketizer.
`timescale 1ns / 100ps

module annexb_stream_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_stall,
    input  logic [7:0]  data_byte,
    input  logic        packet_first,
    input  logic        packet_last,
    input  logic        packet_ok,
    input  logic [15:0] seq_number,
    input  logic [31:0] rtp_timestamp,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [7:0]  out_byte,
    input  logic        byte_present,
    input  logic        frame_end,
    input  logic        frame_aborted,
    input  logic [31:0] frame_timestamp,
    input  logic [31:0] lost_total,
    input  logic [31:0] reorder_total,
    input  logic [31:0] frames_total,
    input  logic        run_last,
    output int          fail_count,
    output int          pending_count
);
    import rtph264_pkg::*;

    // Bit positions of the start and end flags in the FU header
    localparam int FU_S_BIT = 7;
    localparam int FU_E_BIT = 6;

    typedef struct packed {
        logic [7:0]  data;
        logic        present;
        logic        unit_end;
        logic        unit_abort;
        logic [31:0] ts;
        logic [31:0] lost;
        logic [31:0] reorder;
        logic [31:0] frames;
        logic        last;
    } annexb_result_t;

    annexb_result_t annexb_expected[$];
    annexb_result_t step_buf[4];
    annexb_result_t want;
    int             step_n;

    // Predicted depacketizer state
    logic [15:0] exp_seq;
    logic [31:0] lost_cnt;
    logic [31:0] reorder_cnt;
    logic [31:0] frame_cnt;
    logic [1:0]  pos;
    kind_t       kind;
    logic [7:0]  fu_ind_hold;
    logic        unit_open;
    logic [31:0] unit_ts;
    logic        skip;
    logic        end_bit;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? CNT_MAX : sum[31:0];
    endfunction

    task automatic emit_byte(input logic [7:0] value, input logic present);
        if (step_n < 4)
        begin
            step_buf[step_n] = '0;
            step_buf[step_n].data = present ? value : 8'h00;
            step_buf[step_n].present = present;
            step_buf[step_n].ts = unit_ts;
            step_n++;
        end
    endtask

    task automatic emit_start_code();
        emit_byte(SC_ZERO, 1'b1);
        emit_byte(SC_ZERO, 1'b1);
        emit_byte(SC_ONE, 1'b1);
    endtask

    // Count the unit and mark the last result of this byte as its end
    task automatic close_unit();
        frame_cnt = sat_add(frame_cnt, 32'd1);
        unit_open = 1'b0;
        if (step_n == 0)
            emit_byte(8'h00, 1'b0);
        step_buf[step_n - 1].unit_end = 1'b1;
    endtask

    // Advance the predicted state by one payload byte and queue its results
    task automatic depacketize_byte(input logic [7:0] b, input logic first, input logic last,
                                    input logic ok, input logic [15:0] seq,
                                    input logic [31:0] ts);
        logic        abandon;
        logic [15:0] diff;
        int          k;
        step_n = 0;
        abandon = 1'b0;
        if (first)
        begin
            // A new packet drops whatever unit the previous one left open
            if (kind != KIND_NONE && unit_open)
            begin
                abandon = 1'b1;
                unit_open = 1'b0;
            end
            kind = KIND_NONE;
            pos = 2'd0;
            skip = 1'b0;
            end_bit = 1'b0;
            if (!ok)
                skip = 1'b1;
            else
            begin
                if (seq != exp_seq)
                begin
                    diff = seq - exp_seq;
                    reorder_cnt = sat_add(reorder_cnt, 32'd1);
                    if (diff > 16'd1)
                        lost_cnt = sat_add(lost_cnt, {16'd0, diff} - 32'd1);
                    if (unit_open)
                    begin
                        abandon = 1'b1;
                        unit_open = 1'b0;
                    end
                end
                exp_seq = seq + 16'd1;
                if (b[4:0] == FU_A_TYPE)
                begin
                    kind = KIND_FU_KEEP;
                    fu_ind_hold = b;
                    pos = 2'd1;
                end
                else
                begin
                    if (unit_open)
                        abandon = 1'b1;
                    kind = KIND_SINGLE;
                    unit_open = 1'b1;
                    unit_ts = ts;
                    pos = 2'd1;
                    emit_start_code();
                    emit_byte(b, 1'b1);
                    if (last)
                        close_unit();
                end
            end
        end
        else if (kind != KIND_NONE && !skip)
        begin
            if (kind == KIND_SINGLE)
            begin
                emit_byte(b, 1'b1);
                if (last)
                    close_unit();
            end
            else if (pos == 2'd1)
            begin
                // FU header: a start fragment rebuilds the NAL header
                end_bit = b[FU_E_BIT];
                pos = 2'd2;
                if (b[FU_S_BIT])
                begin
                    if (unit_open)
                        abandon = 1'b1;
                    unit_open = 1'b1;
                    unit_ts = ts;
                    kind = KIND_FU_KEEP;
                    emit_start_code();
                    emit_byte((fu_ind_hold & NRI_MASK) | (b & NAL_TYPE_MASK), 1'b1);
                end
                else
                    kind = unit_open ? KIND_FU_KEEP : KIND_FU_DROP;
                if (last && kind == KIND_FU_KEEP && end_bit)
                    close_unit();
            end
            else if (kind == KIND_FU_KEEP)
            begin
                emit_byte(b, 1'b1);
                if (last && end_bit)
                    close_unit();
            end
        end

        if (last)
        begin
            kind = KIND_NONE;
            pos = 2'd0;
            skip = 1'b0;
            end_bit = 1'b0;
        end

        if (abandon)
        begin
            if (step_n == 0)
                emit_byte(8'h00, 1'b0);
            step_buf[0].unit_abort = 1'b1;
        end

        // Stamp the counters as they stand after the whole byte
        for (k = 0; k < step_n; k++)
        begin
            step_buf[k].lost = lost_cnt;
            step_buf[k].reorder = reorder_cnt;
            step_buf[k].frames = frame_cnt;
            step_buf[k].last = (k == step_n - 1);
            annexb_expected = {annexb_expected, step_buf[k]};
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // Predict on input transactions, compare on result transactions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_seq = '0;
            lost_cnt = '0;
            reorder_cnt = '0;
            frame_cnt = '0;
            pos = '0;
            kind = KIND_NONE;
            fu_ind_hold = '0;
            unit_open = 1'b0;
            unit_ts = '0;
            skip = 1'b0;
            end_bit = 1'b0;
            annexb_expected.delete();
            fail_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                depacketize_byte(data_byte, packet_first, packet_last, packet_ok,
                                 seq_number, rtp_timestamp);
            if (result_valid && !result_stall)
            begin
                if (annexb_expected.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual byte %0h",
                             $time, out_byte);
                    fail_count++;
                end
                else
                begin
                    want = annexb_expected.pop_front();
                    check_field("out_byte", want.data, out_byte);
                    check_field("byte_present", want.present, byte_present);
                    check_field("frame_end", want.unit_end, frame_end);
                    check_field("frame_aborted", want.unit_abort, frame_aborted);
                    check_field("frame_timestamp", want.ts, frame_timestamp);
                    check_field("lost_total", want.lost, lost_total);
                    check_field("reorder_total", want.reorder, reorder_total);
                    check_field("frames_total", want.frames, frames_total);
                    check_field("run_last", want.last, run_last);
                end
            end
            pending_count = annexb_expected.size();
        end
    end

endmodule

>>> tb/rtp_h264_nal_depacketizer_top_tb.sv
// Testbench top: clock, reset, packet stimulus and verdict for the RTP H.264 depacketizer.
`timescale 1ns / 100ps

module rtp_h264_nal_depacketizer_top_tb;
    import rtph264_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_BYTES = 75;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic [7:0]  data_byte = '0;
    logic        packet_first = 1'b0;
    logic        packet_last = 1'b0;
    logic        packet_ok = 1'b0;
    logic [15:0] seq_number = '0;
    logic [31:0] rtp_timestamp = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        byte_present;
    logic        frame_end;
    logic        frame_aborted;
    logic [31:0] frame_timestamp;
    logic [31:0] lost_total;
    logic [31:0] reorder_total;
    logic [31:0] frames_total;
    logic        run_last;

    int          check_failures;
    int          expect_pending;
    int          idle_cycles = 0;
    int          sender_quiet = 0;
    int          stall_left = 0;
    int          free_left = 0;
    int          stall_roll;
    int          live_bytes = 0;
    logic [15:0] next_seq = '0;
    logic [7:0]  pkt_bytes[$];

    rtp_h264_nal_depacketizer_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .data_byte      (data_byte),
        .packet_first   (packet_first),
        .packet_last    (packet_last),
        .packet_ok      (packet_ok),
        .seq_number     (seq_number),
        .rtp_timestamp  (rtp_timestamp),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .out_byte       (out_byte),
        .byte_present   (byte_present),
        .frame_end      (frame_end),
        .frame_aborted  (frame_aborted),
        .frame_timestamp(frame_timestamp),
        .lost_total     (lost_total),
        .reorder_total  (reorder_total),
        .frames_total   (frames_total),
        .run_last       (run_last)
    );

    annexb_stream_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .data_byte      (data_byte),
        .packet_first   (packet_first),
        .packet_last    (packet_last),
        .packet_ok      (packet_ok),
        .seq_number     (seq_number),
        .rtp_timestamp  (rtp_timestamp),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .out_byte       (out_byte),
        .byte_present   (byte_present),
        .frame_end      (frame_end),
        .frame_aborted  (frame_aborted),
        .frame_timestamp(frame_timestamp),
        .lost_total     (lost_total),
        .reorder_total  (reorder_total),
        .frames_total   (frames_total),
        .run_last       (run_last),
        .fail_count     (check_failures),
        .pending_count  (expect_pending)
    );

    // 50 MHz clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Stall the result side: short bursts, a few long holds, some free stretches
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            result_stall <= 1'b0;
            if (free_left > 0)
                free_left--;
            else
            begin
                stall_roll = $urandom_range(0, 99);
                if (stall_roll < 15)
                    free_left = $urandom_range(20, 60);
                else if (stall_roll < 25)
                begin
                    stall_left = $urandom_range(10, 35);
                    free_left = $urandom_range(1, 4);
                end
                else
                begin
                    stall_left = $urandom_range(1, 3);
                    free_left = $urandom_range(0, 4);
                end
            end
        end
    end

    // End the run when no transaction moves on either channel for too long
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Pick the idle cycles before the next byte: mostly none or short, rarely long
    function automatic int sender_gap();
        int roll;
        if (sender_quiet > 0)
        begin
            sender_quiet--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 5)
            sender_quiet = $urandom_range(15, 40);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Take the next sequence number, now and then jumping ahead, back or anywhere
    function automatic logic [15:0] take_seq();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            next_seq = 16'($urandom);
        else if (roll == 1)
            next_seq = next_seq + 16'($urandom_range(2, 6));
        else if (roll == 2)
            next_seq = next_seq - 16'($urandom_range(1, 3));
        take_seq = next_seq;
        next_seq = next_seq + 16'd1;
    endfunction

    // Drive one payload byte and hold it until the transaction completes
    task automatic send_byte(input logic [7:0] value, input logic first, input logic last,
                             input logic ok, input logic [15:0] seq, input logic [31:0] ts);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        data_byte <= value;
        packet_first <= first;
        packet_last <= last;
        packet_ok <= ok;
        seq_number <= seq;
        rtp_timestamp <= ts;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // Send pkt_bytes as one packet; later bytes carry noise in seq_number, packet_ok, rtp_timestamp
    task automatic send_pkt(input logic [15:0] seq, input logic [31:0] ts, input logic ok,
                            input logic closed);
        logic [15:0] byte_seq;
        logic [31:0] byte_ts;
        int          i;
        if (ok)
            live_bytes += pkt_bytes.size();
        for (i = 0; i < pkt_bytes.size(); i++)
        begin
            byte_seq = seq;
            byte_ts = ts;
            if (i > 0 && $urandom_range(0, 7) == 0)
                byte_seq = 16'($urandom);
            if (i > 0 && $urandom_range(0, 7) == 0)
                byte_ts = $urandom;
            send_byte(pkt_bytes[i], i == 0, closed && (i == pkt_bytes.size() - 1),
                      (i == 0) ? ok : 1'($urandom_range(0, 1)), byte_seq, byte_ts);
        end
    endtask

    task automatic send_single(input logic [15:0] seq, input logic [31:0] ts, input logic ok,
                               input logic closed, input int len);
        int         unit_type;
        logic [7:0] rnd;
        int         i;
        rnd = 8'($urandom);
        unit_type = $urandom_range(0, 30);
        if (unit_type >= FU_A_TYPE)
            unit_type++;
        pkt_bytes.delete();
        pkt_bytes = {pkt_bytes, {rnd[7:5], unit_type[4:0]}};
        for (i = 1; i < len; i++)
            pkt_bytes = {pkt_bytes, 8'($urandom)};
        send_pkt(seq, ts, ok, closed);
    endtask

    // FU-A packet; a payload of -1 sends the FU indicator alone
    task automatic send_fu(input logic [15:0] seq, input logic [31:0] ts, input logic ok,
                           input logic closed, input logic s_bit, input logic e_bit,
                           input int payload);
        logic [7:0] rnd;
        int         i;
        rnd = 8'($urandom);
        pkt_bytes.delete();
        pkt_bytes = {pkt_bytes, {rnd[7:5], FU_A_TYPE}};
        if (payload >= 0)
        begin
            rnd = 8'($urandom);
            pkt_bytes = {pkt_bytes, {s_bit, e_bit, rnd[5:0]}};
            for (i = 0; i < payload; i++)
                pkt_bytes = {pkt_bytes, 8'($urandom)};
        end
        send_pkt(seq, ts, ok, closed);
    endtask

    initial
    begin : stimulus
        int          choice;
        int          mid;
        int          stop_at;
        logic [31:0] ts;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single units, a full FU-A unit, and the corner cases
        send_single(16'h0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 1);
        send_single(16'h0001, 32'h0000_0000, 1'b1, 1'b1, 1);
        send_fu(16'd2, $urandom, 1'b1, 1'b1, 1'b1, 1'b0, 1);
        send_fu(16'd3, $urandom, 1'b1, 1'b1, 1'b0, 1'b0, 1);
        // end fragment with no bytes after its header
        send_fu(16'd4, $urandom, 1'b1, 1'b1, 1'b0, 1'b1, 0);
        // fragment with no open start
        send_fu(16'd5, $urandom, 1'b1, 1'b1, 1'b0, 1'b1, 1);
        // FU indicator alone
        send_fu(16'd6, $urandom, 1'b1, 1'b1, 1'b0, 1'b0, -1);
        // invalid packet, then a stray byte outside any packet
        send_single(16'h8000, $urandom, 1'b0, 1'b1, 2);
        send_byte(8'hFF, 1'b0, 1'b1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        // single unit interrupting an open FU-A unit
        send_fu(16'd7, $urandom, 1'b1, 1'b1, 1'b1, 1'b0, 0);
        send_single(16'd8, $urandom, 1'b1, 1'b1, 1);
        // sequence gap while a unit is open, then a truncated packet
        send_fu(16'd9, $urandom, 1'b1, 1'b1, 1'b1, 1'b0, 0);
        send_fu(16'hFFFF, $urandom, 1'b1, 1'b0, 1'b1, 1'b0, 1);
        send_fu(16'h0000, $urandom, 1'b1, 1'b1, 1'b1, 1'b1, 1);
        next_seq = 16'd1;

        // Random: mostly well-formed units, the rest broken or noise
        stop_at = live_bytes + RANDOM_BYTES;
        while (live_bytes < stop_at)
        begin
            choice = $urandom_range(0, 99);
            ts = $urandom;
            if (choice < 40)
            begin
                mid = $urandom_range(0, 2);
                send_fu(take_seq(), ts, 1'b1, 1'b1, 1'b1, 1'b0, $urandom_range(0, 3));
                repeat (mid)
                    send_fu(take_seq(), $urandom, 1'b1, 1'b1, 1'b0, 1'b0,
                            $urandom_range(1, 3));
                send_fu(take_seq(), $urandom, 1'b1, 1'b1, 1'b0, 1'b1, $urandom_range(0, 3));
            end
            else if (choice < 65)
                send_single(take_seq(), ts, 1'b1, 1'b1, $urandom_range(1, 5));
            else if (choice < 71)
                send_fu(take_seq(), ts, 1'b1, 1'b1, 1'b1, 1'b1, $urandom_range(0, 3));
            else if (choice < 77)
                send_fu(take_seq(), ts, 1'b1, 1'b1, 1'b0, 1'($urandom_range(0, 1)),
                        $urandom_range(0, 3));
            else if (choice < 81)
                send_fu(take_seq(), ts, 1'b1, 1'b1, 1'b0, 1'b0, -1);
            else if (choice < 87)
            begin
                if ($urandom_range(0, 1))
                    send_single(16'($urandom), ts, 1'b0, 1'b1, $urandom_range(1, 4));
                else
                    send_fu(16'($urandom), ts, 1'b0, 1'b1, 1'b1, 1'b0,
                            $urandom_range(0, 2));
            end
            else if (choice < 93)
            begin
                if ($urandom_range(0, 1))
                    send_single(take_seq(), ts, 1'b1, 1'b0, $urandom_range(1, 3));
                else
                    send_fu(take_seq(), ts, 1'b1, 1'b0, 1'b1, 1'b0, $urandom_range(0, 2));
            end
            else
                send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 16'($urandom), $urandom);
        end
        item_valid <= 1'b0;

        // Drain the outstanding results, then watch for strays
        @(negedge clk);
        while (expect_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (check_failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
src/rtph264_pkg.sv
src/rtph264_front.sv
src/rtph264_queue.sv
src/rtph264_back.sv
src/rtp_h264_nal_depacketizer_top.sv
tb/annexb_stream_checker.sv
tb/rtp_h264_nal_depacketizer_top_tb.sv
